FILE: hdl/sbct_pkg.sv
// ----------------------------------------------------------------------------
// sbct_pkg: shared types and constants for the swept box collision time block
// Field widths, bus widths, normal codes and the per-axis sideband.
// ----------------------------------------------------------------------------
package sbct_pkg;

	localparam int TIME_FRAC_BITS_DEF = 16;

	localparam int POS_W  = 24;   // signed coordinate / velocity
	localparam int SIZE_W = 23;   // unsigned size
	localparam int GAP_W  = 27;   // exact gap width
	localparam int ET_W   = 17;   // entry_time field width
	localparam int NRM_W  = 2;    // normal component width

	localparam int IN_W  = 240;   // input tdata, byte padded
	localparam int OUT_W = 24;    // output tdata, byte padded

	localparam logic signed [NRM_W-1:0] NORM_POS  = 2'sb01;
	localparam logic signed [NRM_W-1:0] NORM_NEG  = 2'sb11;
	localparam logic signed [NRM_W-1:0] NORM_NONE = 2'sb00;

	typedef struct packed {
		logic gap_neg;   // entry gap below zero
		logic vzero;     // no motion on this axis
	} axis_side_t;

endpackage

FILE: hdl/sbct_axis.sv
// ----------------------------------------------------------------------------
// sbct_axis: per-axis front end
// Forms entry and exit gaps, then magnitudes, quotient signs and saturation.
// ----------------------------------------------------------------------------
module sbct_axis #(
	parameter int TFB = sbct_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [sbct_pkg::POS_W-1:0] mp,
	input  logic        [sbct_pkg::SIZE_W-1:0] ms,
	input  logic signed [sbct_pkg::POS_W-1:0] vel,
	input  logic signed [sbct_pkg::POS_W-1:0] tp,
	input  logic        [sbct_pkg::SIZE_W-1:0] ts,
	output logic [sbct_pkg::GAP_W+TFB-1:0]    div_in,
	output logic [sbct_pkg::GAP_W+TFB-1:0]    div_out,
	output logic [sbct_pkg::POS_W-1:0]        vmag,
	output logic                              neg_in,
	output logic                              neg_out,
	output logic                              sat_in,
	output logic                              sat_out,
	output sbct_pkg::axis_side_t              side
);
	import sbct_pkg::*;

	localparam int DW = GAP_W + TFB;

	logic signed [GAP_W-1:0] near_gap, far_gap;
	logic signed [GAP_W-1:0] gin_s1, gout_s1;
	logic signed [POS_W-1:0] vel_s1;
	logic        [GAP_W-1:0] min_s2, mout_s2;
	logic        [POS_W-1:0] vmag_s2;
	logic                    nin_s2, nout_s2, sin_s2, sout_s2;
	axis_side_t              side_s2;
	logic        [GAP_W-1:0] mag_in_c, mag_out_c;
	logic        [POS_W-1:0] vmag_c;

	assign near_gap = GAP_W'(tp) - GAP_W'(mp) - GAP_W'({1'b0, ms});
	assign far_gap  = GAP_W'(tp) + GAP_W'({1'b0, ts}) - GAP_W'(mp);

	always_ff @(posedge clk) begin
		if (en) begin
			vel_s1 <= vel;
			if (vel > 0) begin
				gin_s1  <= near_gap;
				gout_s1 <= far_gap;
			end else begin
				gin_s1  <= far_gap;
				gout_s1 <= near_gap;
			end
		end
	end

	assign mag_in_c  = gin_s1[GAP_W-1]  ? GAP_W'(-gin_s1)  : GAP_W'(gin_s1);
	assign mag_out_c = gout_s1[GAP_W-1] ? GAP_W'(-gout_s1) : GAP_W'(gout_s1);
	assign vmag_c    = vel_s1[POS_W-1]  ? POS_W'(-vel_s1)  : POS_W'(vel_s1);

	// quotient exceeds the cap exactly when gap >= 4 * velocity
	always_ff @(posedge clk) begin
		if (en) begin
			min_s2          <= mag_in_c;
			mout_s2         <= mag_out_c;
			vmag_s2         <= vmag_c;
			nin_s2          <= gin_s1[GAP_W-1] ^ vel_s1[POS_W-1];
			nout_s2         <= gout_s1[GAP_W-1] ^ vel_s1[POS_W-1];
			sin_s2          <= (GAP_W+1)'(mag_in_c)  >= (GAP_W+1)'({vmag_c, 2'b00});
			sout_s2         <= (GAP_W+1)'(mag_out_c) >= (GAP_W+1)'({vmag_c, 2'b00});
			side_s2.gap_neg <= gin_s1[GAP_W-1];
			side_s2.vzero   <= (vel_s1 == '0);
		end
	end

	assign div_in  = DW'(min_s2)  << TFB;
	assign div_out = DW'(mout_s2) << TFB;
	assign vmag    = vmag_s2;
	assign neg_in  = nin_s2;
	assign neg_out = nout_s2;
	assign sat_in  = sin_s2;
	assign sat_out = sout_s2;
	assign side    = side_s2;

endmodule

FILE: hdl/sbct_div_cell.sv
// ----------------------------------------------------------------------------
// sbct_div_cell: one restoring division step
// Decides one quotient bit and hands the remainder to the next cell.
// ----------------------------------------------------------------------------
module sbct_div_cell #(
	parameter int TFB  = sbct_pkg::TIME_FRAC_BITS_DEF,
	parameter int STEP = 0
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [sbct_pkg::GAP_W+TFB-1:0]    rem_i,
	input  logic [sbct_pkg::POS_W-1:0]        dv_i,
	input  logic [TFB+1:0]                    q_i,
	input  logic                              neg_i,
	input  logic                              sat_i,
	output logic [sbct_pkg::GAP_W+TFB-1:0]    rem_o,
	output logic [sbct_pkg::POS_W-1:0]        dv_o,
	output logic [TFB+1:0]                    q_o,
	output logic                              neg_o,
	output logic                              sat_o
);
	import sbct_pkg::*;

	localparam int DW = GAP_W + TFB;

	logic [DW-1:0]  dsh;
	logic           ge;
	logic [TFB+1:0] q_nx;

	assign dsh = DW'(dv_i) << STEP;
	assign ge  = rem_i >= dsh;

	// set this cell's quotient bit, pass the rest through
	always_comb begin
		q_nx       = q_i;
		q_nx[STEP] = ge;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o      <= ge ? rem_i - dsh : rem_i;
			dv_o       <= dv_i;
			q_o        <= q_nx;
			neg_o      <= neg_i;
			sat_o      <= sat_i;
		end
	end

endmodule

FILE: hdl/swept_box_collision_time.sv
// ----------------------------------------------------------------------------
// swept_box_collision_time: swept box against static box contact time
// Four pipelined dividers in a chain of step cells, one item per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one box pair per transfer (moving box with its
//   displacement per frame, and a static box). m_* channel returns one
//   result per pair: hit flag, entry time in frame units and the unit
//   normal of the struck face.
//   A pair passes the gap and magnitude forming of the axis front ends,
//   one quotient bit per cell in the divider chain (TIME_FRAC_BITS + 2
//   cells), and then the result register.
//   Throughput is one pair per cycle while the output is not stalled;
//   divider cells pass partial remainders on, so pairs follow back to back.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and s_tready drops in the same cycle; no result is lost.
//   Reset clears all valid flags; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module swept_box_collision_time #(
	parameter int TIME_FRAC_BITS = sbct_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// mover_x, mover_y, mover_width, mover_height, mover_vel_x, mover_vel_y,
	// target_x, target_y, target_width, target_height, zero pad
	input  logic [sbct_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// hit, entry_time, normal_x, normal_y, zero pad
	output logic [sbct_pkg::OUT_W-1:0] m_tdata
);
	import sbct_pkg::*;

	localparam int TFB = TIME_FRAC_BITS;
	localparam int QW  = TFB + 2;
	localparam int TW  = QW + 1;
	localparam int DW  = GAP_W + TFB;
	localparam int NL  = 4;   // lanes: x entry, x exit, y entry, y exit

	localparam logic signed [TW-1:0] T_ONE = TW'(longint'(1) << TFB);
	localparam logic        [QW-1:0] T_CAP = {QW{1'b1}};

	logic adv;

	logic [DW-1:0]    rem_c [0:QW][0:NL-1];
	logic [POS_W-1:0] dv_c  [0:QW][0:NL-1];
	logic [QW-1:0]    q_c   [0:QW][0:NL-1];
	logic             neg_c [0:QW][0:NL-1];
	logic             sat_c [0:QW][0:NL-1];
	axis_side_t       sx_c  [0:QW];
	axis_side_t       sy_c  [0:QW];
	logic             vld_c [0:QW];

	logic             vld_s1, vld_s2;
	logic [POS_W-1:0] vmx, vmy;

	logic signed [TW-1:0] t_res [0:NL-1];
	logic signed [TW-1:0] xin, xout, yin, yout, ent, ext;
	logic                 miss;
	logic signed [NRM_W-1:0] nx_c, ny_c;

	logic                    out_vld_q;
	logic                    hit_q;
	logic [ET_W-1:0]         et_q;
	logic signed [NRM_W-1:0] nx_q, ny_q;

	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;

	sbct_axis #(.TFB(TFB)) u_ax_x (
		.clk     (clk),
		.en      (adv),
		.mp      (s_tdata[23:0]),
		.ms      (s_tdata[70:48]),
		.vel     (s_tdata[117:94]),
		.tp      (s_tdata[165:142]),
		.ts      (s_tdata[212:190]),
		.div_in  (rem_c[0][0]),
		.div_out (rem_c[0][1]),
		.vmag    (vmx),
		.neg_in  (neg_c[0][0]),
		.neg_out (neg_c[0][1]),
		.sat_in  (sat_c[0][0]),
		.sat_out (sat_c[0][1]),
		.side    (sx_c[0])
	);

	sbct_axis #(.TFB(TFB)) u_ax_y (
		.clk     (clk),
		.en      (adv),
		.mp      (s_tdata[47:24]),
		.ms      (s_tdata[93:71]),
		.vel     (s_tdata[141:118]),
		.tp      (s_tdata[189:166]),
		.ts      (s_tdata[235:213]),
		.div_in  (rem_c[0][2]),
		.div_out (rem_c[0][3]),
		.vmag    (vmy),
		.neg_in  (neg_c[0][2]),
		.neg_out (neg_c[0][3]),
		.sat_in  (sat_c[0][2]),
		.sat_out (sat_c[0][3]),
		.side    (sy_c[0])
	);

	assign dv_c[0][0] = vmx;
	assign dv_c[0][1] = vmx;
	assign dv_c[0][2] = vmy;
	assign dv_c[0][3] = vmy;
	assign vld_c[0]   = vld_s2;

	for (genvar l = 0; l < NL; l++) begin : g_q0
		assign q_c[0][l] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	for (genvar st = 0; st < QW; st++) begin : g_stage
		for (genvar l = 0; l < NL; l++) begin : g_lane
			sbct_div_cell #(.TFB(TFB), .STEP(QW-1-st)) u_cell (
				.clk   (clk),
				.en    (adv),
				.rem_i (rem_c[st][l]),
				.dv_i  (dv_c[st][l]),
				.q_i   (q_c[st][l]),
				.neg_i (neg_c[st][l]),
				.sat_i (sat_c[st][l]),
				.rem_o (rem_c[st+1][l]),
				.dv_o  (dv_c[st+1][l]),
				.q_o   (q_c[st+1][l]),
				.neg_o (neg_c[st+1][l]),
				.sat_o (sat_c[st+1][l])
			);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sx_c[st+1] <= sx_c[st];
				sy_c[st+1] <= sy_c[st];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[st+1] <= 1'b0;
			end else if (adv) begin
				vld_c[st+1] <= vld_c[st];
			end
		end
	end

	// saturate and apply sign
	for (genvar l = 0; l < NL; l++) begin : g_res
		logic [QW-1:0] tm;
		assign tm       = sat_c[QW][l] ? T_CAP : q_c[QW][l];
		assign t_res[l] = neg_c[QW][l] ? -TW'(tm) : TW'(tm);
	end

	always_comb begin
		xin  = sx_c[QW].vzero ? -TW'(T_CAP) : t_res[0];
		xout = sx_c[QW].vzero ?  TW'(T_CAP) : t_res[1];
		yin  = sy_c[QW].vzero ? -TW'(T_CAP) : t_res[2];
		yout = sy_c[QW].vzero ?  TW'(T_CAP) : t_res[3];
		ent  = (xin > yin) ? xin : yin;
		ext  = (xout < yout) ? xout : yout;
		miss = (ent > ext) || (xin < 0 && yin < 0) || (xin > T_ONE) || (yin > T_ONE);
		nx_c = NORM_NONE;
		ny_c = NORM_NONE;
		if (xin > yin) begin
			nx_c = sx_c[QW].gap_neg ? NORM_POS : NORM_NEG;
		end else begin
			ny_c = sy_c[QW].gap_neg ? NORM_POS : NORM_NEG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_c[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= !miss;
			et_q  <= miss ? ET_W'(T_ONE) : ET_W'(ent);
			nx_q  <= miss ? NORM_NONE : nx_c;
			ny_q  <= miss ? NORM_NONE : ny_c;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, ny_q, nx_q, et_q, hit_q};

	a_miss_clean : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !hit_q |-> et_q == ET_W'(T_ONE) && nx_q == NORM_NONE
			&& ny_q == NORM_NONE)
		else $error("miss result carries time or normal");

	a_one_normal : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && hit_q |-> (nx_q != NORM_NONE) != (ny_q != NORM_NONE))
		else $error("hit result without exactly one normal axis");

	a_hold_chain : assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_c[QW]) && $stable(vld_s2))
		else $error("pipeline moved during output stall");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the swept box collision time block
// Box pairs go in over the s_* channel. A local model of the swept
// box test predicts each result, and the result is compared field by
// field as it leaves on the m_* channel. Both channels idle at random,
// and the receiver once holds off for a long stretch to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
	import sbct_pkg::*;

	localparam int  TFRAC     = 16;
	localparam longint T_ONE  = longint'(1) << TFRAC;
	localparam longint T_CAP  = (longint'(1) << (TFRAC + 2)) - 1;
	localparam int  STALL_LIMIT = 5000;
	localparam int  HOLD_CYCLES = 300;
	localparam int  TAIL_CYCLES = 40;

	typedef struct {
		logic signed [POS_W-1:0] mx, my, vx, vy, tx, ty;
		logic [SIZE_W-1:0]       mw, mh, tw, th;
	} box_pair_t;

	typedef struct {
		logic                    hit;
		logic [ET_W-1:0]         entry_time;
		logic signed [NRM_W-1:0] normal_x, normal_y;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	contact_t contact_q[$];
	int  errors = 0;
	bit  calm = 1'b0;
	int  hold_req = 0;
	int  hold_seen = 0;
	int  hold_left = 0;
	int  idle_cycles = 0;
	contact_t got, want;

	swept_box_collision_time uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint magnitude(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// Saturated quotient in frame units; vel is never zero here.
	function automatic longint sweep_time(input longint gap, input longint vel);
		longint q;
		q = (magnitude(gap) << TFRAC) / magnitude(vel);
		if (q > T_CAP)
			q = T_CAP;
		return ((gap < 0) != (vel < 0)) ? -q : q;
	endfunction

	task automatic axis_times(input longint mp, ms, v, tp, ts,
			output longint gap_in, t_in, t_out);
		longint gap_out;
		if (v > 0) begin
			gap_in  = tp - (mp + ms);
			gap_out = (tp + ts) - mp;
		end else begin
			gap_in  = (tp + ts) - mp;
			gap_out = tp - (mp + ms);
		end
		if (v == 0) begin
			t_in  = -T_CAP;
			t_out = T_CAP;
		end else begin
			t_in  = sweep_time(gap_in, v);
			t_out = sweep_time(gap_out, v);
		end
	endtask

	task automatic predict_contact(input box_pair_t p, output contact_t r);
		longint gx, gy, xin, xout, yin, yout, t_ent, t_ext;
		axis_times(longint'(p.mx), longint'(p.mw), longint'(p.vx),
			longint'(p.tx), longint'(p.tw), gx, xin, xout);
		axis_times(longint'(p.my), longint'(p.mh), longint'(p.vy),
			longint'(p.ty), longint'(p.th), gy, yin, yout);
		t_ent = xin > yin ? xin : yin;
		t_ext = xout < yout ? xout : yout;
		r.normal_x = NORM_NONE;
		r.normal_y = NORM_NONE;
		if (t_ent > t_ext || (xin < 0 && yin < 0) || xin > T_ONE || yin > T_ONE) begin
			r.hit = 1'b0;
			r.entry_time = T_ONE[ET_W-1:0];
		end else begin
			r.hit = 1'b1;
			r.entry_time = t_ent[ET_W-1:0];
			if (xin > yin)
				r.normal_x = gx < 0 ? NORM_POS : NORM_NEG;
			else
				r.normal_y = gy < 0 ? NORM_POS : NORM_NEG;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// Offer one pair until it is taken, idling beforehand now and then.
	task automatic send_pair(input box_pair_t p);
		contact_t r;
		if (!calm && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, p.th, p.tw, p.ty, p.tx, p.vy, p.vx, p.mh, p.mw, p.my, p.mx};
		predict_contact(p, r);
		do @(posedge clk); while (!s_tready);
		contact_q.push_back(r);
	endtask

	task automatic release_input();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic box_pair_t zero_pair();
		box_pair_t p;
		p.mx = '0; p.my = '0; p.vx = '0; p.vy = '0; p.tx = '0; p.ty = '0;
		p.mw = '0; p.mh = '0; p.tw = '0; p.th = '0;
		return p;
	endfunction

	// Mostly pairs close enough to meet within a frame, some wholly random.
	function automatic box_pair_t random_pair();
		box_pair_t p;
		int span;
		if ($urandom_range(9) < 3) begin
			p.mx = $urandom; p.my = $urandom; p.vx = $urandom; p.vy = $urandom;
			p.tx = $urandom; p.ty = $urandom; p.mw = $urandom; p.mh = $urandom;
			p.tw = $urandom; p.th = $urandom;
		end else begin
			span = 1 << $urandom_range(16, 6);
			p.mx = $signed($urandom_range(2 * span)) - span;
			p.my = $signed($urandom_range(2 * span)) - span;
			p.mw = $urandom_range(span);
			p.mh = $urandom_range(span);
			p.tw = $urandom_range(span);
			p.th = $urandom_range(span);
			p.vx = $urandom_range(9) == 0 ? 0 : $signed($urandom_range(4 * span)) - 2 * span;
			p.vy = $urandom_range(9) == 0 ? 0 : $signed($urandom_range(4 * span)) - 2 * span;
			p.tx = p.mx + $signed($urandom_range(4 * span)) - 2 * span;
			p.ty = p.my + $signed($urandom_range(4 * span)) - 2 * span;
		end
		return p;
	endfunction

	task automatic wait_drained();
		wait (contact_q.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		box_pair_t p;
		send_pair(zero_pair());
		p = zero_pair();
		p.mx = 24'sh7FFFFF; p.my = 24'sh800000; p.vx = 24'sh800000; p.vy = 24'sh7FFFFF;
		p.tx = 24'sh800000; p.ty = 24'sh7FFFFF; p.mw = '1; p.mh = '1; p.tw = '1; p.th = '1;
		send_pair(p);
		p.vx = 24'sh7FFFFF; p.vy = 24'sh800000; p.mx = 24'sh800000; p.tx = 24'sh7FFFFF;
		send_pair(p);
		// head-on along each direction, touching at half a frame
		p = zero_pair();
		p.mw = 256; p.mh = 256; p.tw = 256; p.th = 256;
		p.tx = 512; p.vx = 512; send_pair(p);
		p.tx = -512; p.vx = -512; send_pair(p);
		p.tx = 0; p.vx = 0; p.ty = 512; p.vy = 512; send_pair(p);
		p.ty = -512; p.vy = -512; send_pair(p);
		// overlap at rest: both entries at minus infinity
		p.ty = 0; p.vy = 0; send_pair(p);
		// contact exactly at time zero, exactly at time one, and at time two (a miss)
		p.tx = 256; p.vx = 256; send_pair(p);
		p.tx = 512; send_pair(p);
		p.tx = 768; send_pair(p);
		// diagonal with equal entries: y normal wins the tie
		p.tx = 512; p.ty = 512; p.vx = 512; p.vy = 512; send_pair(p);
		// smallest velocity, huge gap saturates
		p = zero_pair(); p.tx = 24'sh400000; p.vx = 1; send_pair(p);
		p.vx = -1; send_pair(p);
		// moving away
		p.tx = 1024; p.vx = -256; p.mw = 256; p.tw = 256; p.th = 256; p.mh = 256;
		send_pair(p);
		// zero size boxes sliding past each other
		p = zero_pair(); p.tx = 128; p.vx = 256; p.ty = 1; p.vy = 0; send_pair(p);
		p.ty = 0; send_pair(p);
		release_input();
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			if (i == n / 3)
				calm = 1'b1;
			if (i == n / 2)
				calm = 1'b0;
			send_pair(random_pair());
		end
		release_input();
	endtask

	// Receiver holds off while pairs keep coming, so s_tready must drop.
	task automatic test_backpressure(input int n);
		hold_req++;
		for (int i = 0; i < n; i++)
			send_pair(random_pair());
		release_input();
	endtask

	task automatic test_pause_until_empty();
		for (int i = 0; i < 40; i++)
			send_pair(random_pair());
		release_input();
		wait (contact_q.size() == 0);
		for (int i = 0; i < 40; i++)
			send_pair(random_pair());
		release_input();
	endtask

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 9);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.hit = m_tdata[0];
			got.entry_time = m_tdata[17:1];
			got.normal_x = m_tdata[19:18];
			got.normal_y = m_tdata[21:20];
			if (contact_q.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = contact_q.pop_front();
				if (got.hit !== want.hit)
					report_mismatch($sformatf("hit %0b, want %0b", got.hit, want.hit));
				if (got.entry_time !== want.entry_time)
					report_mismatch($sformatf("entry_time %0d, want %0d",
						got.entry_time, want.entry_time));
				if (got.normal_x !== want.normal_x)
					report_mismatch($sformatf("normal_x %0d, want %0d",
						got.normal_x, want.normal_x));
				if (got.normal_y !== want.normal_y)
					report_mismatch($sformatf("normal_y %0d, want %0d",
						got.normal_y, want.normal_y));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(700);
		test_backpressure(120);
		test_pause_until_empty();
		test_random(550);
		wait_drained();
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

FILE: sim.f
hdl/sbct_pkg.sv
hdl/sbct_axis.sv
hdl/sbct_div_cell.sv
hdl/swept_box_collision_time.sv
tb/tb_top.sv
